FILE: design/ihbs_pkg.sv
`timescale 1ns / 1ps
package ihbs_pkg;

  // Default fraction bits of all heights and velocities.
  localparam int FRAC_BITS_DEF = 16;

  // Field widths.
  localparam int H_W   = 24;
  localparam int V_W   = 24;
  localparam int Q_W   = 32;
  localparam int G_W   = 24;
  localparam int DRY_W = 16;
  localparam int CFG_W = 24;

  // Products and roots.
  localparam int PROD_W = 48;
  localparam int ROOT_W = 24;

  // Register reset values.
  localparam logic [G_W-1:0]   GRAVITY_RESET = 24'd642908;
  localparam logic [DRY_W-1:0] DRY_RESET     = 16'd1;

  // Register indexes.
  typedef enum logic {
    CFG_GRAVITY = 1'b0,
    CFG_DRY     = 1'b1
  } cfg_idx_t;

  // Saturation limits of a 24 bit signed velocity.
  localparam logic signed [V_W-1:0] VEL_MAX = 24'sh7FFFFF;
  localparam logic signed [V_W-1:0] VEL_MIN = 24'sh800000;

  // Fields carried alongside the root pipeline.
  typedef struct packed {
    logic [H_W-1:0]        hin;
    logic signed [V_W-1:0] u;
    logic signed [V_W-1:0] v;
    logic [H_W-1:0]        hfix;
    logic                  upper;
    logic [PROD_W-1:0]     ghfix;
    logic                  sub;
  } side_t;

endpackage

FILE: design/ihbs_if.sv
`timescale 1ns / 1ps
// Input word channel.
interface ihbs_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [ihbs_pkg::H_W-1:0]              inside_height;
  logic signed [ihbs_pkg::V_W-1:0]       inside_normal_velocity;
  logic signed [ihbs_pkg::V_W-1:0]       inside_tangent_velocity;
  logic [ihbs_pkg::H_W-1:0]              imposed_height;
  logic signed [ihbs_pkg::Q_W-1:0]       imposed_discharge;
  logic                                  upper_side;

  modport source (output valid, inside_height, inside_normal_velocity,
                  inside_tangent_velocity, imposed_height, imposed_discharge,
                  upper_side, input ready);
  modport sink (input valid, inside_height, inside_normal_velocity,
                inside_tangent_velocity, imposed_height, imposed_discharge,
                upper_side, output ready);
endinterface

// Result word channel.
interface ihbs_out_if;
  logic                            valid;
  logic                            ready;
  logic [ihbs_pkg::H_W-1:0]        ghost_height;
  logic signed [ihbs_pkg::V_W-1:0] ghost_normal_velocity;
  logic signed [ihbs_pkg::V_W-1:0] ghost_tangent_velocity;

  modport source (output valid, ghost_height, ghost_normal_velocity,
                  ghost_tangent_velocity, input ready);
  modport sink (input valid, ghost_height, ghost_normal_velocity,
                ghost_tangent_velocity, output ready);
endinterface

FILE: design/ihbs_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
module ihbs_sqrt (
  input  logic                              clk,
  input  logic                              en,
  input  logic [ihbs_pkg::PROD_W-1:0]       op,
  output logic [ihbs_pkg::ROOT_W-1:0]       root
);
  localparam int NST = ihbs_pkg::ROOT_W;
  localparam int RW  = ihbs_pkg::ROOT_W + 3;
  localparam int PW  = ihbs_pkg::PROD_W;

  logic [RW-1:0]                 rem_r  [NST];
  logic [ihbs_pkg::ROOT_W-1:0]   root_r [NST];
  logic [PW-1:0]                 op_r   [NST];

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_st
      logic [RW-1:0]               src_rem;
      logic [ihbs_pkg::ROOT_W-1:0] src_root;
      logic [PW-1:0]               src_op;
      logic [RW-1:0]               rem_sh;
      logic [RW-1:0]               trial;
      logic                        take;

      if (k == 0) begin : g_first
        assign src_rem  = '0;
        assign src_root = '0;
        assign src_op   = op;
      end else begin : g_next
        assign src_rem  = rem_r[k-1];
        assign src_root = root_r[k-1];
        assign src_op   = op_r[k-1];
      end

      // Bring in the next two operand bits and try the next root bit.
      assign rem_sh = {src_rem[RW-3:0], src_op[PW-1:PW-2]};
      assign trial  = {1'b0, src_root, 2'b01};
      assign take   = rem_sh >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= take ? (rem_sh - trial) : rem_sh;
          root_r[k] <= {src_root[ihbs_pkg::ROOT_W-2:0], take};
          op_r[k]   <= {src_op[PW-3:0], 2'b00};
        end
      end
    end
  endgenerate

  assign root = root_r[NST-1];
endmodule

FILE: design/ihbs_div.sv
`timescale 1ns / 1ps
// Pipelined saturating signed divide of discharge * 2^FRAC_BITS by height.
// One setup stage, one quotient bit per stage, one sign stage.
module ihbs_div #(
  parameter int FRAC_BITS = ihbs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ihbs_pkg::Q_W-1:0]   q,
  input  logic [ihbs_pkg::H_W-1:0]          d,
  input  logic                              zero,
  output logic signed [ihbs_pkg::V_W-1:0]   quo
);
  localparam int AW  = ihbs_pkg::Q_W + FRAC_BITS;
  localparam int QB  = ihbs_pkg::V_W - 1;
  localparam int DW  = ihbs_pkg::H_W;
  localparam int CW  = (AW > DW + QB) ? AW : DW + QB;
  localparam int NIT = QB;

  logic [ihbs_pkg::Q_W-1:0] mag;
  logic [AW-1:0]            a;
  logic [AW-1:0]            a_hi;
  logic                     sat;

  logic          neg_r  [NIT+1];
  logic          sat_r  [NIT+1];
  logic          zero_r [NIT+1];
  logic [DW-1:0] rem_r  [NIT+1];
  logic [QB-1:0] low_r  [NIT+1];
  logic [QB-1:0] quo_r  [NIT+1];
  logic [DW-1:0] d_r    [NIT+1];
  logic signed [ihbs_pkg::V_W-1:0] out_r;

  // Magnitude and overflow check: the quotient saturates once it reaches 2^23.
  assign mag  = q[ihbs_pkg::Q_W-1] ? (~q + 1'b1) : q;
  assign a    = {mag, {FRAC_BITS{1'b0}}};
  assign a_hi = a >> QB;
  assign sat  = CW'(a) >= (CW'(d) << QB);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0]  <= q[ihbs_pkg::Q_W-1];
      sat_r[0]  <= sat;
      zero_r[0] <= zero;
      rem_r[0]  <= a_hi[DW-1:0];
      low_r[0]  <= a[QB-1:0];
      quo_r[0]  <= '0;
      d_r[0]    <= d;
    end
  end

  genvar k;
  generate
    for (k = 1; k <= NIT; k++) begin : g_it
      logic [DW:0] t;
      logic [DW:0] diff;
      logic        ge;

      // Restoring step: shift in one dividend bit, subtract if it fits.
      assign t    = {rem_r[k-1], low_r[k-1][QB-1]};
      assign ge   = t >= {1'b0, d_r[k-1]};
      assign diff = t - {1'b0, d_r[k-1]};

      always_ff @(posedge clk) begin
        if (en) begin
          neg_r[k]  <= neg_r[k-1];
          sat_r[k]  <= sat_r[k-1];
          zero_r[k] <= zero_r[k-1];
          rem_r[k]  <= ge ? diff[DW-1:0] : t[DW-1:0];
          low_r[k]  <= {low_r[k-1][QB-2:0], 1'b0};
          quo_r[k]  <= {quo_r[k-1][QB-2:0], ge};
          d_r[k]    <= d_r[k-1];
        end
      end
    end
  endgenerate

  // Apply sign, saturation and the dry case.
  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[NIT]) begin
        out_r <= '0;
      end else if (sat_r[NIT]) begin
        out_r <= neg_r[NIT] ? ihbs_pkg::VEL_MIN : ihbs_pkg::VEL_MAX;
      end else if (neg_r[NIT]) begin
        out_r <= -$signed({1'b0, quo_r[NIT]});
      end else begin
        out_r <= $signed({1'b0, quo_r[NIT]});
      end
    end
  end

  assign quo = out_r;
endmodule

FILE: design/imposed_height_boundary_state_core.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; the 24 stage root pipeline and the 25 stage
// divide pipeline set the depth, and the whole pipeline holds only when the
// last stage holds a word while a result is blocked.
// Reset: synchronous, active low; clears all valid bits and restores the
// gravity and dry threshold registers to their defaults.
module imposed_height_boundary_state_core #(
  parameter int FRAC_BITS = ihbs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ihbs_in_if.sink                       in_ch,
  ihbs_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  ihbs_pkg::cfg_idx_t            cfg_index,
  input  logic [ihbs_pkg::CFG_W-1:0]    cfg_wdata
);
  localparam int DLY  = ihbs_pkg::ROOT_W;
  localparam int NVLD = DLY + 3;
  localparam int UBW  = 28;
  localparam int UUW  = 2 * UBW;

  logic [ihbs_pkg::G_W-1:0]   gravity_r;
  logic [ihbs_pkg::DRY_W-1:0] dry_r;

  logic                          adv;
  logic [NVLD-1:0]               vld_r;

  logic [ihbs_pkg::PROD_W-1:0]   ghin_r;
  logic signed [ihbs_pkg::PROD_W-1:0] uu_full;
  logic [ihbs_pkg::PROD_W-1:0]   uu_r;
  ihbs_pkg::side_t               s1_r;
  ihbs_pkg::side_t               s1_side;
  ihbs_pkg::side_t               dl_r [DLY];
  logic                          div_zero;

  logic [ihbs_pkg::ROOT_W-1:0]   cin;
  logic [ihbs_pkg::ROOT_W-1:0]   cfix;
  logic signed [ihbs_pkg::V_W-1:0] uf;

  logic signed [UBW-1:0]         cdiff2;
  logic signed [UBW-1:0]         ub_nxt;
  logic signed [UBW-1:0]         ub26_r;
  logic signed [ihbs_pkg::V_W-1:0] uf26_r;
  ihbs_pkg::side_t               s26_r;

  logic signed [UUW-1:0]         ubub_full;
  logic signed [UBW-1:0]         ub27_r;
  logic [UUW-1:0]                ubub27_r;
  logic signed [ihbs_pkg::V_W-1:0] uf27_r;
  ihbs_pkg::side_t               s27_r;

  logic                          inflow;
  logic                          copy_in;
  logic                          use_imp;
  logic signed [ihbs_pkg::V_W-1:0] ub_sat;
  logic                          out_valid_r;
  logic [ihbs_pkg::H_W-1:0]      oh_r;
  logic signed [ihbs_pkg::V_W-1:0] ou_r;
  logic signed [ihbs_pkg::V_W-1:0] ov_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= ihbs_pkg::GRAVITY_RESET;
      dry_r     <= ihbs_pkg::DRY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ihbs_pkg::CFG_GRAVITY: gravity_r <= cfg_wdata[ihbs_pkg::G_W-1:0];
        ihbs_pkg::CFG_DRY:     dry_r     <= cfg_wdata[ihbs_pkg::DRY_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves unless its last stage holds a word that cannot leave.
  assign adv         = !(vld_r[NVLD-1] && out_valid_r && !out_ch.ready);
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NVLD-2:0], in_ch.valid};
    end
  end

  // Full width square of the inside normal velocity.
  assign uu_full = in_ch.inside_normal_velocity * in_ch.inside_normal_velocity;

  // Stage 1: products of gravity with both heights, and the squared velocity.
  always_ff @(posedge clk) begin
    if (adv) begin
      ghin_r       <= ihbs_pkg::PROD_W'(gravity_r * in_ch.inside_height);
      s1_r.ghfix   <= ihbs_pkg::PROD_W'(gravity_r * in_ch.imposed_height);
      uu_r         <= $unsigned(uu_full);
      s1_r.hin     <= in_ch.inside_height;
      s1_r.u       <= in_ch.inside_normal_velocity;
      s1_r.v       <= in_ch.inside_tangent_velocity;
      s1_r.hfix    <= in_ch.imposed_height;
      s1_r.upper   <= in_ch.upper_side;
      s1_r.sub     <= 1'b0;
    end
  end

  // Subcritical test on the inside cell, exact on the products.
  always_comb begin
    s1_side     = s1_r;
    s1_side.sub = uu_r <= ghin_r;
  end

  // Side fields follow the root pipeline.
  always_ff @(posedge clk) begin
    if (adv) begin
      dl_r[0] <= s1_side;
      for (int i = 1; i < DLY; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

  ihbs_sqrt u_sqrt_in (
    .clk  (clk),
    .en   (adv),
    .op   (ghin_r),
    .root (cin)
  );

  ihbs_sqrt u_sqrt_fix (
    .clk  (clk),
    .en   (adv),
    .op   (s1_r.ghfix),
    .root (cfix)
  );

  // Imposed velocity is zero below the dry threshold or for zero discharge.
  assign div_zero = ({{(ihbs_pkg::H_W-ihbs_pkg::DRY_W){1'b0}}, dry_r} >
                     in_ch.imposed_height) || (in_ch.imposed_discharge == '0);

  ihbs_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .en   (adv),
    .q    (in_ch.imposed_discharge),
    .d    (in_ch.imposed_height),
    .zero (div_zero),
    .quo  (uf)
  );

  // Stage 26: Riemann invariant velocity at full width.
  assign cdiff2 = ($signed({4'b0000, cin}) - $signed({4'b0000, cfix})) <<< 1;
  assign ub_nxt = dl_r[DLY-1].upper ? (UBW'(dl_r[DLY-1].u) + cdiff2)
                                    : (UBW'(dl_r[DLY-1].u) - cdiff2);

  always_ff @(posedge clk) begin
    if (adv) begin
      ub26_r <= ub_nxt;
      uf26_r <= uf;
      s26_r  <= dl_r[DLY-1];
    end
  end

  // Full width square of the ghost velocity.
  assign ubub_full = ub26_r * ub26_r;

  // Stage 27: square of the ghost velocity.
  always_ff @(posedge clk) begin
    if (adv) begin
      ubub27_r <= $unsigned(ubub_full);
      ub27_r   <= ub26_r;
      uf27_r   <= uf26_r;
      s27_r    <= s26_r;
    end
  end

  // Final choice between the Riemann state, imposed values and the copy.
  assign inflow  = s27_r.upper ? (s27_r.u <= 0) : (s27_r.u >= 0);
  assign use_imp = !s27_r.sub || (ubub27_r > UUW'(s27_r.ghfix));
  assign copy_in = use_imp && !inflow;
  assign ub_sat  = (ub27_r > UBW'(ihbs_pkg::VEL_MAX)) ? ihbs_pkg::VEL_MAX :
                   (ub27_r < UBW'(ihbs_pkg::VEL_MIN)) ? ihbs_pkg::VEL_MIN :
                   ub27_r[ihbs_pkg::V_W-1:0];

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && vld_r[NVLD-1]) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_r[NVLD-1]) begin
      if (copy_in) begin
        oh_r <= s27_r.hin;
        ou_r <= s27_r.u;
        ov_r <= s27_r.v;
      end else if (use_imp) begin
        oh_r <= s27_r.hfix;
        ou_r <= uf27_r;
        ov_r <= '0;
      end else begin
        oh_r <= s27_r.hfix;
        ou_r <= ub_sat;
        ov_r <= '0;
      end
    end
  end

  assign out_ch.valid                  = out_valid_r;
  assign out_ch.ghost_height           = oh_r;
  assign out_ch.ghost_normal_velocity  = ou_r;
  assign out_ch.ghost_tangent_velocity = ov_r;

`ifndef SYNTHESIS
  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(vld_r[NVLD-1]))
    else $error("result word appeared without a word in the last stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_valid_r && !out_ch.ready && vld_r[NVLD-1]))
    else $error("input stalled without a blocked result");
`endif
endmodule
